/* rtl/core/wrs_pkg.sv */
package wrs_pkg;

  // field widths
  localparam int FUNC_W    = 2;
  localparam int ENTRY_W   = 4;
  localparam int WEIGHT_W  = 16;
  localparam int FRAC_IN_W = 16;
  localparam int CHOSEN_W  = 4;
  localparam int CNT_W     = 5;
  localparam int DAMP_W    = 17;
  localparam int DAMP_FRAC = 16;

  // stream layout
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 8;

  // datapath widths: item_count is at most 31, so the total of 33-bit
  // scaled weights fits in 38 bits
  localparam int TOT_W   = 38;
  localparam int CHUNK_W = 19;
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int PTOT_W  = TOT_W + FRAC_IN_W;

  localparam logic [DAMP_W-1:0] DAMP_ONE = 17'h10000;
  localparam logic [DAMP_W-1:0] DAMP_MAX = 17'h1ffff;
  localparam logic [PROD_W-1:0] DAMP_RND = PROD_W'(32768);

  // item kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_DRAW    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  // register indexes
  localparam logic REG_ITEM_COUNT = 1'b0;
  localparam logic REG_PULL       = 1'b1;

  // microprogram steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] ST_SUM_MUL   = 4'd1;
  localparam logic [STEP_W-1:0] ST_SUM_ACC   = 4'd2;
  localparam logic [STEP_W-1:0] ST_TGT_LO    = 4'd3;
  localparam logic [STEP_W-1:0] ST_TGT_HI    = 4'd4;
  localparam logic [STEP_W-1:0] ST_TGT_SUM   = 4'd5;
  localparam logic [STEP_W-1:0] ST_SCAN_MUL  = 4'd6;
  localparam logic [STEP_W-1:0] ST_SCAN_ACC  = 4'd7;
  localparam logic [STEP_W-1:0] ST_DECIDE    = 4'd8;
  localparam logic [STEP_W-1:0] ST_MISS_OUT  = 4'd9;
  localparam logic [STEP_W-1:0] ST_MISS_WAIT = 4'd10;
  localparam logic [STEP_W-1:0] ST_HIT_MUL   = 4'd11;
  localparam logic [STEP_W-1:0] ST_HIT_OUT   = 4'd12;
  localparam logic [STEP_W-1:0] ST_HIT_WAIT  = 4'd13;

  typedef enum logic [2:0] {
    MUL_HOLD = 3'd0,
    MUL_WD   = 3'd1,
    MUL_TLO  = 3'd2,
    MUL_THI  = 3'd3,
    MUL_PULL = 3'd4
  } mul_sel_e;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_START  = 3'd2,
    COND_NOT_LAST  = 3'd3,
    COND_SCAN_MORE = 3'd4,
    COND_HIT       = 3'd5,
    COND_OUT_FREE  = 3'd6
  } cond_e;

  typedef struct packed {
    mul_sel_e          mul_sel;
    logic              accept_en;
    logic              idx_clr;
    logic              idx_inc;   // on taken jump only
    logic              tot_clr;
    logic              tot_add;
    logic              save_part;
    logic              tgt_sum;
    logic              acc_clr;
    logic              acc_add;
    logic              emit;      // on taken jump only
    logic              emit_fb;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   take;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic last;
    logic scan_more;
    logic hit;
    logic out_free;
  } status_t;

  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    w.mul_sel = MUL_HOLD;
    w.cond    = COND_NEVER;
    w.target  = ST_IDLE;
    unique case (step)
      ST_IDLE: begin
        w.accept_en = 1'b1;
        w.idx_clr   = 1'b1;
        w.tot_clr   = 1'b1;
        w.cond      = COND_NO_START;
        w.target    = ST_IDLE;
      end
      ST_SUM_MUL: w.mul_sel = MUL_WD;
      ST_SUM_ACC: begin
        w.tot_add = 1'b1;
        w.idx_inc = 1'b1;
        w.cond    = COND_NOT_LAST;
        w.target  = ST_SUM_MUL;
      end
      ST_TGT_LO: begin
        w.mul_sel = MUL_TLO;
        w.idx_clr = 1'b1;
      end
      ST_TGT_HI: begin
        w.mul_sel   = MUL_THI;
        w.save_part = 1'b1;
      end
      ST_TGT_SUM: begin
        w.tgt_sum = 1'b1;
        w.acc_clr = 1'b1;
      end
      ST_SCAN_MUL: w.mul_sel = MUL_WD;
      ST_SCAN_ACC: begin
        w.acc_add = 1'b1;
        w.idx_inc = 1'b1;
        w.cond    = COND_SCAN_MORE;
        w.target  = ST_SCAN_MUL;
      end
      ST_DECIDE: begin
        w.cond   = COND_HIT;
        w.target = ST_HIT_MUL;
      end
      ST_MISS_OUT: begin
        w.emit    = 1'b1;
        w.emit_fb = 1'b1;
        w.cond    = COND_OUT_FREE;
        w.target  = ST_IDLE;
      end
      ST_MISS_WAIT: begin
        w.cond   = COND_ALWAYS;
        w.target = ST_MISS_OUT;
      end
      ST_HIT_MUL: w.mul_sel = MUL_PULL;
      ST_HIT_OUT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_FREE;
        w.target = ST_IDLE;
      end
      ST_HIT_WAIT: begin
        w.cond   = COND_ALWAYS;
        w.target = ST_HIT_OUT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/wrs_regs.sv */
module wrs_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        reg_sel_i,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic [wrs_pkg::CNT_W-1:0]   item_count_o,
  output logic [wrs_pkg::DAMP_W-1:0]  pull_factor_o
);
  import wrs_pkg::*;

  logic              wr_en;
  logic [CNT_W-1:0]  item_count_q;
  logic [DAMP_W-1:0] pull_q;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q <= CNT_W'(16);
      pull_q       <= DAMP_ONE;
    end else if (wr_en) begin
      if (reg_sel_i == REG_ITEM_COUNT) begin
        item_count_q <= pwdata[CNT_W-1:0];
      end else begin
        pull_q <= pwdata[DAMP_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (reg_sel_i)
      REG_ITEM_COUNT: prdata = 32'(item_count_q);
      REG_PULL:       prdata = 32'(pull_q);
    endcase
  end

  assign item_count_o  = item_count_q;
  assign pull_factor_o = pull_q;

endmodule

/* rtl/core/wrs_seq.sv */
module wrs_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wrs_pkg::status_t  status_i,
  output wrs_pkg::ctl_t     ctl_o
);
  import wrs_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uc;
  logic              take;

  always_comb begin
    uc = ucode_rom(step_q);
    unique case (uc.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_START:  take = !status_i.start;
      COND_NOT_LAST:  take = !status_i.last;
      COND_SCAN_MORE: take = status_i.scan_more;
      COND_HIT:       take = status_i.hit;
      COND_OUT_FREE:  take = status_i.out_free;
      default:        take = 1'b0;
    endcase
    step_d = take ? uc.target : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctl_o.uc   = uc;
  assign ctl_o.take = take;

endmodule

/* rtl/core/wrs_dp.sv */
module wrs_dp #(
  parameter int MAX_ITEMS     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wrs_pkg::ctl_t                 ctl_i,
  output wrs_pkg::status_t              status_o,
  input  logic [wrs_pkg::CNT_W-1:0]     item_count_i,
  input  logic [wrs_pkg::DAMP_W-1:0]    pull_factor_i,
  input  logic                          s_tvalid_i,
  input  logic [wrs_pkg::FUNC_W-1:0]    func_i,
  input  logic [wrs_pkg::ENTRY_W-1:0]   entry_index_i,
  input  logic [wrs_pkg::WEIGHT_W-1:0]  weight_value_i,
  input  logic [wrs_pkg::FRAC_IN_W-1:0] random_fraction_i,
  input  logic                          m_tready_i,
  output logic                          m_tvalid_o,
  output logic [wrs_pkg::CHOSEN_W-1:0]  chosen_index_o,
  output logic                          by_fallback_o
);
  import wrs_pkg::*;

  localparam int IDX_W = $clog2(MAX_ITEMS);

  logic                 accept, start, wr_en, restart;
  logic [IDX_W-1:0]     wr_addr, last_idx;
  logic [IDX_W-1:0]     idx_q, idx_d;

  logic [WEIGHT_W-1:0]  wmem [MAX_ITEMS];
  logic [DAMP_W-1:0]    dmem [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] dval_q;
  logic [WEIGHT_W-1:0]  w_rd_q;
  logic [DAMP_W-1:0]    dm_rd_q;
  logic                 dv_rd_q;
  logic [DAMP_W-1:0]    d_rd;

  logic [FRAC_IN_W-1:0] r_q;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    mul_res;
  logic [PROD_W-1:0]    prod_q, part_q;
  logic [TOT_W-1:0]     total_q, acc_q, acc_new;
  logic [PTOT_W-1:0]    ptot_q;
  logic                 hit_now, hit_q;

  logic [PROD_W-1:0]    rnd;
  logic [PROD_W-DAMP_FRAC-1:0] dmp_sh;
  logic [DAMP_W-1:0]    dmp_new;
  logic                 emit_now, dmp_wr;

  logic                 out_valid_q;
  logic [CHOSEN_W-1:0]  out_idx_q;
  logic                 out_fb_q;

  assign accept  = s_tvalid_i && ctl_i.uc.accept_en;
  assign start   = accept && (func_i == FUNC_DRAW);
  assign restart = accept && (func_i == FUNC_RESTART);
  assign wr_en   = accept && (func_i == FUNC_WRITE) && (32'(entry_index_i) < MAX_ITEMS);
  assign wr_addr = IDX_W'(entry_index_i);

  // clamp item_count into 1..MAX_ITEMS
  always_comb begin
    priority if (item_count_i == '0) begin
      last_idx = '0;
    end else if (32'(item_count_i) > MAX_ITEMS) begin
      last_idx = IDX_W'(MAX_ITEMS - 1);
    end else begin
      last_idx = IDX_W'(item_count_i - CNT_W'(1));
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (ctl_i.uc.idx_clr) begin
      idx_d = '0;
    end else if (ctl_i.uc.idx_inc && ctl_i.take) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  // stores, read every cycle at the next index
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wmem[wr_addr] <= weight_value_i;
    end
    w_rd_q <= wmem[idx_d];
  end

  always_ff @(posedge clk_i) begin
    if (dmp_wr) begin
      dmem[idx_q] <= dmp_new;
    end
    dm_rd_q <= dmem[idx_d];
  end

  // an entry without its valid bit reads as 1.0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dval_q  <= '0;
      dv_rd_q <= 1'b0;
    end else begin
      if (restart) begin
        dval_q <= '0;
      end else if (dmp_wr) begin
        dval_q[idx_q] <= 1'b1;
      end
      dv_rd_q <= dval_q[idx_d];
    end
  end

  assign d_rd = dv_rd_q ? dm_rd_q : DAMP_ONE;

  // shared multiplier
  always_comb begin
    unique case (ctl_i.uc.mul_sel)
      MUL_WD: begin
        mul_a = MUL_A_W'(w_rd_q);
        mul_b = d_rd;
      end
      MUL_TLO: begin
        mul_a = MUL_A_W'(total_q[CHUNK_W-1:0]);
        mul_b = MUL_B_W'(r_q);
      end
      MUL_THI: begin
        mul_a = MUL_A_W'(total_q[TOT_W-1:CHUNK_W]);
        mul_b = MUL_B_W'(r_q);
      end
      MUL_PULL: begin
        mul_a = MUL_A_W'(d_rd);
        mul_b = pull_factor_i;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  assign acc_new = acc_q + TOT_W'(prod_q);
  assign hit_now = PTOT_W'(acc_new) > (ptot_q >> FRACTION_BITS);

  always_ff @(posedge clk_i) begin
    if (start) begin
      r_q <= random_fraction_i;
    end
    if (ctl_i.uc.mul_sel != MUL_HOLD) begin
      prod_q <= mul_res;
    end
    if (ctl_i.uc.save_part) begin
      part_q <= prod_q;
    end
    if (ctl_i.uc.tgt_sum) begin
      ptot_q <= PTOT_W'(part_q) + (PTOT_W'(prod_q) << CHUNK_W);
    end
    if (ctl_i.uc.tot_clr) begin
      total_q <= '0;
    end else if (ctl_i.uc.tot_add) begin
      total_q <= total_q + TOT_W'(prod_q);
    end
    if (ctl_i.uc.acc_clr) begin
      acc_q <= '0;
    end else if (ctl_i.uc.acc_add) begin
      acc_q <= acc_new;
      hit_q <= hit_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // damping update: round half up, saturate
  assign rnd     = prod_q + DAMP_RND;
  assign dmp_sh  = rnd[PROD_W-1:DAMP_FRAC];
  assign dmp_new = (|dmp_sh[PROD_W-DAMP_FRAC-1:DAMP_W]) ? DAMP_MAX : dmp_sh[DAMP_W-1:0];

  assign emit_now = ctl_i.uc.emit && ctl_i.take;
  assign dmp_wr   = emit_now && !ctl_i.uc.emit_fb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_now) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      out_idx_q <= CHOSEN_W'(idx_q);
      out_fb_q  <= ctl_i.uc.emit_fb;
    end
  end

  assign status_o.start     = start;
  assign status_o.last      = (idx_q == last_idx);
  assign status_o.scan_more = !hit_now && (idx_q != last_idx);
  assign status_o.hit       = hit_q;
  assign status_o.out_free  = !out_valid_q || m_tready_i;

  assign m_tvalid_o     = out_valid_q;
  assign chosen_index_o = out_idx_q;
  assign by_fallback_o  = out_fb_q;

endmodule

/* rtl/core/weighted_random_selector.sv */
// Draw: two passes of two steps per entry through one shared 20x17 multiplier.
// Write and restart words are taken in the idle step without leaving it.
// One item in flight; a finished result waits in the output register while
// the next word is taken. Reset: damping factors 1.0, item_count 16,
// pull_factor 1.0, output empty; weights are undefined until written.
module weighted_random_selector #(
  parameter int MAX_ITEMS     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // entry_index[3:0], weight_value[19:4], random_fraction[35:20], zero pad
  input  logic [wrs_pkg::S_TDATA_W-1:0]   s_tdata,
  // func[1:0]
  input  logic [wrs_pkg::FUNC_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // chosen_index[3:0], zero pad
  output logic [wrs_pkg::M_TDATA_W-1:0]   m_tdata,
  // by_fallback[0]
  output logic [0:0]                      m_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import wrs_pkg::*;

  ctl_t                  ctl;
  status_t               status;
  logic [CNT_W-1:0]      item_count;
  logic [DAMP_W-1:0]     pull_factor;
  logic [CHOSEN_W-1:0]   chosen_index;
  logic                  by_fallback;

  assign pready = 1'b1;

  wrs_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .reg_sel_i     (paddr[2]),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .item_count_o  (item_count),
    .pull_factor_o (pull_factor)
  );

  wrs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctl_o    (ctl)
  );

  wrs_dp #(
    .MAX_ITEMS     (MAX_ITEMS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .status_o          (status),
    .item_count_i      (item_count),
    .pull_factor_i     (pull_factor),
    .s_tvalid_i        (s_tvalid),
    .func_i            (s_tuser),
    .entry_index_i     (s_tdata[3:0]),
    .weight_value_i    (s_tdata[19:4]),
    .random_fraction_i (s_tdata[35:20]),
    .m_tready_i        (m_tready),
    .m_tvalid_o        (m_tvalid),
    .chosen_index_o    (chosen_index),
    .by_fallback_o     (by_fallback)
  );

  assign s_tready   = ctl.uc.accept_en;
  assign m_tdata    = M_TDATA_W'(chosen_index);
  assign m_tuser[0] = by_fallback;

endmodule

/* test/weighted_random_selector_tb.sv */
module weighted_random_selector_tb;
  import wrs_pkg::*;

  localparam int ENTRIES          = 16;
  localparam int FRACTION_BITS_TB = 16;
  localparam int SETTLE_CYCLES    = 80;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int PHASE_WORDS      = 192;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHOSEN_W-1:0] index;
    logic                fallback;
  } pick_t;

  typedef struct packed {
    logic                 is_reg;
    logic                 reg_sel;
    logic [31:0]          reg_val;
    logic [FUNC_W-1:0]    func;
    logic [ENTRY_W-1:0]   idx;
    logic [WEIGHT_W-1:0]  wt;
    logic [FRAC_IN_W-1:0] frac;
    logic                 typed;
    logic [CHOSEN_W-1:0]  t_idx;
    logic                 t_fb;
  } step_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic [FUNC_W-1:0]     s_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [0:0]            m_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // shadow of the block state
  logic [WEIGHT_W-1:0] weight_mem [ENTRIES];
  logic [DAMP_W-1:0]   damp_mem   [ENTRIES];
  logic [CNT_W-1:0]    cfg_count;
  logic [DAMP_W-1:0]   cfg_pull;

  pick_t pending_picks[$];
  step_t script[$];
  int    err_count     = 0;
  int    cycle_count   = 0;
  int    send_idle_pct = 21;
  int    recv_idle_pct = 49;

  weighted_random_selector dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("weighted_random_selector_tb: errors");
      $finish;
    end
  end

  function automatic void restart_damping();
    for (int i = 0; i < ENTRIES; i++) damp_mem[i] = DAMP_ONE;
  endfunction

  function automatic pick_t draw_pick(input logic [FRAC_IN_W-1:0] frac);
    int unsigned n;
    logic [79:0] total;
    logic [79:0] target;
    logic [79:0] acc;
    logic [79:0] damped;
    logic        found;
    pick_t       res;
    n = cfg_count;
    if (n == 0) n = 1;
    if (n > ENTRIES) n = ENTRIES;
    total = '0;
    for (int i = 0; i < n; i++) total += 80'(weight_mem[i]) * 80'(damp_mem[i]);
    target = (80'(frac) * total) >> FRACTION_BITS_TB;
    res.index    = CHOSEN_W'(n - 1);
    res.fallback = 1'b1;
    found = 1'b0;
    acc = '0;
    for (int i = 0; i < n; i++) begin
      if (!found) begin
        acc += 80'(weight_mem[i]) * 80'(damp_mem[i]);
        if (acc > target) begin
          // round half up, then clip at the top of the damping range
          damped = (80'(damp_mem[i]) * 80'(cfg_pull) + 80'd32768) >> 16;
          if (damped > 80'(DAMP_MAX)) damped = 80'(DAMP_MAX);
          damp_mem[i]  = DAMP_W'(damped);
          res.index    = CHOSEN_W'(i);
          res.fallback = 1'b0;
          found = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] func, input logic [ENTRY_W-1:0] idx,
                           input logic [WEIGHT_W-1:0] wt, input logic [FRAC_IN_W-1:0] frac,
                           input logic typed, input logic [CHOSEN_W-1:0] t_idx,
                           input logic t_fb);
    pick_t p;
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, frac, wt, idx};
    s_tuser  <= func;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    case (func)
      FUNC_WRITE:   weight_mem[idx] = wt;
      FUNC_RESTART: restart_damping();
      FUNC_DRAW: begin
        p = draw_pick(frac);
        if (typed) begin
          p.index    = t_idx;
          p.fallback = t_fb;
        end
        pending_picks = {pending_picks, p};
      end
      default: ;
    endcase
  endtask

  task automatic program_reg(input logic sel, input logic [31:0] value);
    logic [31:0] want;
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_picks.size() != 0);
    // a write or restart word may still be in flight behind the last result
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (sel == REG_ITEM_COUNT) begin
      cfg_count = CNT_W'(value);
      want = 32'(cfg_count);
    end else begin
      cfg_pull = DAMP_W'(value);
      want = 32'(cfg_pull);
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $error("prdata: expected %0d, actual %0d", want, prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    if (roll < 50) return WEIGHT_W'($urandom_range(255, 0));
    return WEIGHT_W'($urandom);
  endfunction

  task automatic random_word();
    int unsigned roll;
    int unsigned frac_roll;
    logic [FRAC_IN_W-1:0] frac;
    roll = $urandom_range(99, 0);
    if (roll < 3) begin
      send_word(FUNC_UNUSED, ENTRY_W'($urandom), WEIGHT_W'($urandom), FRAC_IN_W'($urandom),
                1'b0, '0, 1'b0);
    end else if (roll < 8) begin
      send_word(FUNC_RESTART, ENTRY_W'($urandom), WEIGHT_W'($urandom), FRAC_IN_W'($urandom),
                1'b0, '0, 1'b0);
    end else if (roll < 45) begin
      send_word(FUNC_WRITE, ENTRY_W'($urandom), pick_weight(), FRAC_IN_W'($urandom),
                1'b0, '0, 1'b0);
    end else begin
      frac_roll = $urandom_range(99, 0);
      if (frac_roll < 5) frac = '0;
      else if (frac_roll < 10) frac = '1;
      else frac = FRAC_IN_W'($urandom);
      send_word(FUNC_DRAW, ENTRY_W'($urandom), WEIGHT_W'($urandom), frac, 1'b0, '0, 1'b0);
    end
  endtask

  function automatic void reg_row(input logic sel, input logic [31:0] value);
    step_t s;
    s = '0;
    s.is_reg  = 1'b1;
    s.reg_sel = sel;
    s.reg_val = value;
    script = {script, s};
  endfunction

  function automatic void word_row(input logic [FUNC_W-1:0] func,
                                   input logic [ENTRY_W-1:0] idx,
                                   input logic [WEIGHT_W-1:0] wt,
                                   input logic [FRAC_IN_W-1:0] frac,
                                   input logic typed, input logic [CHOSEN_W-1:0] t_idx,
                                   input logic t_fb);
    step_t s;
    s = '0;
    s.func  = func;
    s.idx   = idx;
    s.wt    = wt;
    s.frac  = frac;
    s.typed = typed;
    s.t_idx = t_idx;
    s.t_fb  = t_fb;
    script = {script, s};
  endfunction

  always @(posedge clk_i) begin : result_check
    pick_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_picks.size() == 0) begin
        $error("unexpected word: chosen_index %0d by_fallback %0d", m_tdata[CHOSEN_W-1:0],
               m_tuser[0]);
        err_count++;
      end else begin
        want = pending_picks.pop_front();
        if (m_tdata[CHOSEN_W-1:0] !== want.index) begin
          $error("chosen_index: expected %0d, actual %0d", want.index,
                 m_tdata[CHOSEN_W-1:0]);
          err_count++;
        end
        if (m_tuser[0] !== want.fallback) begin
          $error("by_fallback: expected %0d, actual %0d", want.fallback, m_tuser[0]);
          err_count++;
        end
      end
    end
    m_tready <= (recv_idle_pct == 0) || ($urandom_range(99, 0) >= recv_idle_pct);
  end

  initial begin
    rst_ni   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    cfg_count = CNT_W'(16);
    cfg_pull  = DAMP_ONE;
    restart_damping();
    for (int i = 0; i < ENTRIES; i++) weight_mem[i] = '0;

    // zero weights fall back to the last entry; pull 0 kills a picked entry;
    // count 0 acts as one entry; pull at its top saturates the damping
    reg_row(REG_ITEM_COUNT, 32'd4);
    word_row(FUNC_WRITE, 4'd0, 16'h0000, 16'h0000, 1'b0, 4'd0, 1'b0);
    word_row(FUNC_WRITE, 4'd1, 16'h0000, 16'h0000, 1'b0, 4'd0, 1'b0);
    word_row(FUNC_WRITE, 4'd2, 16'h0000, 16'h0000, 1'b0, 4'd0, 1'b0);
    word_row(FUNC_WRITE, 4'd3, 16'h0000, 16'h0000, 1'b0, 4'd0, 1'b0);
    word_row(FUNC_DRAW,  4'd0, 16'h0000, 16'h0000, 1'b1, 4'd3, 1'b1);
    word_row(FUNC_DRAW,  4'd0, 16'h0000, 16'hffff, 1'b1, 4'd3, 1'b1);
    word_row(FUNC_WRITE, 4'd0, 16'hffff, 16'h0000, 1'b0, 4'd0, 1'b0);
    word_row(FUNC_DRAW,  4'd0, 16'h0000, 16'h0000, 1'b1, 4'd0, 1'b0);
    word_row(FUNC_WRITE, 4'd3, 16'hffff, 16'h0000, 1'b0, 4'd0, 1'b0);
    word_row(FUNC_DRAW,  4'd0, 16'h0000, 16'hffff, 1'b0, 4'd0, 1'b0);
    word_row(FUNC_UNUSED, 4'd15, 16'hffff, 16'hffff, 1'b0, 4'd0, 1'b0);
    word_row(FUNC_WRITE, 4'd15, 16'hffff, 16'h0000, 1'b0, 4'd0, 1'b0);
    reg_row(REG_PULL, 32'd0);
    word_row(FUNC_DRAW,  4'd0, 16'h0000, 16'h0000, 1'b1, 4'd0, 1'b0);
    word_row(FUNC_DRAW,  4'd0, 16'h0000, 16'h0000, 1'b0, 4'd0, 1'b0);
    word_row(FUNC_DRAW,  4'd0, 16'h0000, 16'h0000, 1'b0, 4'd0, 1'b0);
    word_row(FUNC_RESTART, 4'd0, 16'h0000, 16'h0000, 1'b0, 4'd0, 1'b0);
    word_row(FUNC_DRAW,  4'd0, 16'h0000, 16'h0000, 1'b0, 4'd0, 1'b0);
    reg_row(REG_PULL, 32'd131071);
    reg_row(REG_ITEM_COUNT, 32'd0);
    word_row(FUNC_RESTART, 4'd0, 16'h0000, 16'h0000, 1'b0, 4'd0, 1'b0);
    word_row(FUNC_DRAW,  4'd0, 16'h0000, 16'hffff, 1'b1, 4'd0, 1'b0);
    word_row(FUNC_DRAW,  4'd0, 16'h0000, 16'hffff, 1'b1, 4'd0, 1'b0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_reg) program_reg(script[i].reg_sel, script[i].reg_val);
      else send_word(script[i].func, script[i].idx, script[i].wt, script[i].frac,
                     script[i].typed, script[i].t_idx, script[i].t_fb);
    end

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0, 1: begin
          send_idle_pct = 21;
          recv_idle_pct = 49;
        end
        2, 3: begin
          send_idle_pct = 49;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0: begin
          program_reg(REG_ITEM_COUNT, 32'd16);
          program_reg(REG_PULL, 32'd65536);
          // load every entry before the first draw over all of them
          for (int i = 0; i < ENTRIES; i++)
            send_word(FUNC_WRITE, ENTRY_W'(i), pick_weight(), FRAC_IN_W'($urandom),
                      1'b0, '0, 1'b0);
        end
        1: begin
          program_reg(REG_ITEM_COUNT, 32'd31);
          program_reg(REG_PULL, 32'd131071);
        end
        2: begin
          program_reg(REG_ITEM_COUNT, $urandom_range(16, 1));
          program_reg(REG_PULL, $urandom_range(65536, 0));
        end
        3: begin
          program_reg(REG_ITEM_COUNT, $urandom_range(31, 17));
          program_reg(REG_PULL, 32'd0);
        end
        4: begin
          program_reg(REG_ITEM_COUNT, $urandom_range(31, 0));
          program_reg(REG_PULL, $urandom_range(131071, 0));
        end
        default: begin
          program_reg(REG_ITEM_COUNT, 32'd16);
          program_reg(REG_PULL, $urandom_range(65536, 32768));
        end
      endcase
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (phase == 1 && k == PHASE_WORDS / 2) begin
          // hold the sender until the block has drained
          s_tvalid <= 1'b0;
          do @(posedge clk_i); while (pending_picks.size() != 0);
        end
        random_word();
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_picks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("weighted_random_selector_tb: clean");
    end else begin
      $display("weighted_random_selector_tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/wrs_pkg.sv
rtl/core/wrs_regs.sv
rtl/core/wrs_seq.sv
rtl/core/wrs_dp.sv
rtl/core/weighted_random_selector.sv
test/weighted_random_selector_tb.sv
